>>> hdl/assert_macros.svh
// assertion macros used by the checker file pli_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked at the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pli_pkg.sv
// types, constants and codes for the piecewise linear interpolator
// no dependencies
`default_nettype none
package pli_pkg;
    localparam int MaxKnots = 64;
    localparam int IdxW = $clog2(MaxKnots);
    localparam int CntW = $clog2(MaxKnots + 1);

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_LOW = 3'd2;
    localparam logic [2:0] ST_HIGH = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic [31:0] query_x;
    } t_in;

    typedef struct packed {
        logic signed [31:0] interp_y;
        logic [2:0] status;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture input item
        logic clear;      // reset knot count
        logic append;     // write knot
        logic rd;         // issue memory read at search index
        logic cmp;        // compare read knot against query
        logic mul;        // form product
        logic div_init;   // start division
        logic div_step;   // one quotient bit
        logic fin_lerp;   // result from quotient
        logic fin_clamp;  // result from last read knot y
        logic [2:0] status;
        logic done;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic full;
        logic empty;
        logic last;       // search index is last valid knot
        logic ge;         // read knot x at or beyond query
        logic first;      // search index is zero
        logic eq;         // read knot x equals query
        logic div_last;
    } t_sts;
endpackage
`default_nettype wire

>>> hdl/pli_datapath.sv
// knot memories, search index, multiplier and restoring divider
// depends on pli_pkg
`default_nettype none
module pli_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pli_pkg::t_in   i_item,
    input  wire pli_pkg::t_cmd  i_cmd,
    output pli_pkg::t_sts       o_sts,
    output pli_pkg::t_out       o_res
);
    import pli_pkg::*;

    logic [31:0] r_mem_x [MaxKnots];
    logic [31:0] r_mem_y [MaxKnots];
    logic [31:0] r_rd_x, r_rd_y, r_x0, r_y0;
    logic [CntW-1:0] r_count;
    logic [IdxW-1:0] r_idx;
    t_in r_item;
    logic [63:0] r_prod;
    logic [31:0] r_dx;
    logic r_neg;
    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0] r_bit;
    logic signed [31:0] r_y;
    logic [2:0] r_st;
    logic r_done;

    logic signed [32:0] w_dy;
    logic [31:0] w_mag;
    logic [32:0] w_trial;
    logic [63:0] w_frac;
    logic signed [32:0] w_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem_x[r_count[IdxW-1:0]] <= r_item.knot_x;
            r_mem_y[r_count[IdxW-1:0]] <= r_item.knot_y;
        end
        if (i_cmd.rd) begin
            r_rd_x <= r_mem_x[r_idx];
            r_rd_y <= r_mem_y[r_idx];
        end
    end

    assign w_dy = $signed({r_rd_y[31], r_rd_y}) - $signed({r_y0[31], r_y0});
    assign w_mag = w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
    assign w_trial = {r_rem[31:0], r_prod[63]} - {1'b0, r_dx};
    assign w_frac = r_quo;
    assign w_res = r_neg ? $signed({r_y0[31], r_y0}) - $signed({1'b0, w_frac[31:0]})
                         : $signed({r_y0[31], r_y0}) + $signed({1'b0, w_frac[31:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
            if (i_cmd.clear) r_count <= '0;
            else if (i_cmd.append) r_count <= r_count + 1'b1;
        end
        if (i_cmd.load) begin
            r_item <= i_item;
            r_idx <= '0;
        end
        if (i_cmd.cmp && !(r_rd_x >= r_item.query_x)) begin
            r_x0 <= r_rd_x;
            r_y0 <= r_rd_y;
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(w_mag) * 64'(r_item.query_x - r_x0);
            r_dx <= r_rd_x - r_x0;
            r_neg <= w_dy[32];
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= '0;
            r_bit <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_prod[63]};
                r_quo <= {r_quo[62:0], 1'b0};
            end
            r_prod <= {r_prod[62:0], 1'b0};
            r_bit <= r_bit + 1'b1;
        end
        if (i_cmd.done) begin
            r_st <= i_cmd.status;
            if (i_cmd.fin_lerp) r_y <= w_res[31:0];
            else if (i_cmd.fin_clamp) r_y <= r_rd_y;
            else r_y <= '0;
        end
    end

    assign o_sts.func = r_item.func;
    assign o_sts.full = (r_count == CntW'(MaxKnots));
    assign o_sts.empty = (r_count == '0);
    assign o_sts.last = (CntW'(r_idx) == r_count - 1'b1);
    assign o_sts.ge = (r_rd_x >= r_item.query_x);
    assign o_sts.first = (r_idx == '0);
    assign o_sts.eq = (r_rd_x == r_item.query_x);
    assign o_sts.div_last = (r_bit == 6'd63);
    assign o_res.interp_y = r_y;
    assign o_res.status = r_st;
    logic unused;
    assign unused = r_done;
endmodule
`default_nettype wire

>>> hdl/pli_ctrl.sv
// sequencer for clear, append, query and unused-code items
// depends on pli_pkg
`default_nettype none
module pli_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pli_pkg::t_sts i_sts,
    output pli_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import pli_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CMP = 3'd3;
    localparam logic [2:0] S_MUL = 3'd4;
    localparam logic [2:0] S_DIV = 3'd5;
    localparam logic [2:0] S_FIN = 3'd6;
    localparam logic [2:0] S_LERP = 3'd7;

    logic [2:0] r_state, n_state;
    logic r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done = 1'b0;
        o_cmd = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                o_cmd.done = 1'b1;
                n_done = 1'b1;
                priority case (i_sts.func)
                    FUNC_CLEAR: o_cmd.clear = 1'b1;
                    FUNC_APPEND: begin
                        if (i_sts.full) o_cmd.status = ST_FULL;
                        else o_cmd.append = 1'b1;
                    end
                    FUNC_QUERY: begin
                        if (i_sts.empty) o_cmd.status = ST_EMPTY;
                        else begin
                            o_cmd.done = 1'b0;
                            n_done = 1'b0;
                            o_cmd.rd = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    default: ;
                endcase
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (i_sts.ge) begin
                    if (i_sts.first) begin
                        o_cmd.done = 1'b1;
                        o_cmd.fin_clamp = 1'b1;
                        o_cmd.status = i_sts.eq ? ST_OK : ST_LOW;
                        n_done = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.mul = 1'b1;
                        n_state = S_MUL;
                    end
                end else if (i_sts.last) begin
                    o_cmd.done = 1'b1;
                    o_cmd.fin_clamp = 1'b1;
                    o_cmd.status = ST_HIGH;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.cmp = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.rd = 1'b1;
                n_state = S_READ;
            end
            S_MUL: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_LERP;
            end
            S_LERP: begin
                n_state = S_IDLE;
                n_done = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
endmodule
`default_nettype wire

>>> hdl/pli_fin.sv
// final lerp capture after the divider's last step
// depends on pli_pkg
`default_nettype none
module pli_fin (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_div_last,
    input  wire pli_pkg::t_cmd i_cmd,
    output pli_pkg::t_cmd      o_cmd
);
    import pli_pkg::*;

    logic r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else r_pend <= i_cmd.div_step && i_div_last;
    end

    always_comb begin
        o_cmd = i_cmd;
        o_cmd.fin_lerp = r_pend;
        if (r_pend) begin
            o_cmd.done = 1'b1;
            o_cmd.status = ST_OK;
        end
    end
endmodule
`default_nettype wire

>>> hdl/piecewise_linear_interpolator.sv
// piecewise linear interpolator top level
// depends on pli_pkg, pli_ctrl, pli_fin, pli_datapath
//
// channel   direction  handshake                 payload
// item      in         start high, busy low      i_item (t_in)
// result    out        o_done one-cycle strobe   o_result (t_out)
//
// clear, append, unused code and empty query: result issued from the dispatch state, then registered onto o_done
// clamped query: dispatch, then read and compare states for each knot compared, with an advance state between knots
// interpolated query: as a clamped query, plus multiply, divide and capture states
// knot search reads one entry per read, compare and advance pass from the knot memory port
// synchronous active-low reset empties the table; results cannot be stalled
`default_nettype none
module piecewise_linear_interpolator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pli_pkg::t_in  i_item,
    output logic               o_done,
    output pli_pkg::t_out      o_result
);
    import pli_pkg::*;

    t_cmd w_cmd_raw, w_cmd;
    t_sts w_sts;
    logic w_done;

    pli_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(w_sts),
        .o_cmd(w_cmd_raw), .o_busy(busy), .o_done(w_done)
    );

    pli_fin u_fin (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_div_last(w_sts.div_last),
        .i_cmd(w_cmd_raw), .o_cmd(w_cmd)
    );

    pli_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_res(o_result)
    );

    logic r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else r_vld <= w_cmd.done;
    end
    assign o_done = r_vld;
    logic unused;
    assign unused = w_done;
endmodule
`default_nettype wire

>>> hdl/pli_checker.sv
// port-level checks for the interpolator
// depends on pli_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module pli_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_done,
    input wire pli_pkg::t_out o_result
);
    import pli_pkg::*;

    logic w_empty_res;
    assign w_empty_res = o_done && (o_result.status == ST_EMPTY);

    `ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "no busy after start")
    `ASSERT_IMPL(a_status_range, i_clk, i_rst_n, o_done, o_result.status <= ST_EMPTY, "bad status")
    `ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, w_empty_res, o_result.interp_y == '0, "empty nonzero")
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_done, !o_done, "double strobe")
endmodule

bind piecewise_linear_interpolator pli_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_result(o_result)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// testbench for the piecewise linear interpolator: directed and random clear, append, query and
// unused-code items, checked against an in-bench table model through a small scoreboard class
// depends on pli_pkg and piecewise_linear_interpolator
`timescale 1ns / 1ps
module testbench;
    import pli_pkg::*;

    class interp_board;
        logic [31:0] kx[MaxKnots];
        logic [31:0] ky[MaxKnots];
        int count;
        t_out pending[$];
        int errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function t_out compute(t_in it);
            t_out r;
            int i;
            longint dx, t, dy, mag, frac, y0, y1;
            r.interp_y = '0;
            r.status = ST_OK;
            if (it.func == FUNC_CLEAR) begin
                count = 0;
            end else if (it.func == FUNC_APPEND) begin
                if (count >= MaxKnots) begin
                    r.status = ST_FULL;
                end else begin
                    kx[count] = it.knot_x;
                    ky[count] = it.knot_y;
                    count++;
                end
            end else if (it.func == FUNC_QUERY) begin
                if (count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    i = 0;
                    while (i < count && kx[i] < it.query_x) i++;
                    if (i >= count) begin
                        r.interp_y = ky[count - 1];
                        r.status = ST_HIGH;
                    end else if (i == 0) begin
                        r.interp_y = ky[0];
                        r.status = (it.query_x < kx[0]) ? ST_LOW : ST_OK;
                    end else begin
                        dx = longint'(kx[i]) - longint'(kx[i - 1]);
                        t = longint'(it.query_x) - longint'(kx[i - 1]);
                        y0 = longint'($signed(ky[i - 1]));
                        y1 = longint'($signed(ky[i]));
                        dy = y1 - y0;
                        mag = dy < 0 ? -dy : dy;
                        frac = longint'(($unsigned(mag) * $unsigned(t)) / $unsigned(dx));
                        r.interp_y = 32'(dy < 0 ? y0 - frac : y0 + frac);
                    end
                end
            end
            return r;
        endfunction

        function void note_item(t_in it);
            pending.push_back(compute(it));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result y=%0d st=%0d",
                    got.interp_y, got.status);
                return;
            end
            want = pending.pop_front();
            if (got.interp_y !== want.interp_y || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected y=%0d st=%0d, got y=%0d st=%0d",
                        want.interp_y, want.status, got.interp_y, got.status);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    t_in i_item = '0;
    logic o_done;
    t_out o_result;
    interp_board board = new();
    int idle_pct = 24;
    int stall_count = 0;
    logic [31:0] next_x;

    always #10 i_clk = ~i_clk;

    piecewise_linear_interpolator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_result(o_result);
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count > 20000) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send(input logic [1:0] f, input logic [31:0] x,
                        input logic [31:0] y, input logic [31:0] q);
        t_in it;
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        it.func = f;
        it.knot_x = x;
        it.knot_y = y;
        it.query_x = q;
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(it);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int k;
        k = $urandom_range(99);
        if (k < 3) begin
            send(FUNC_CLEAR, $urandom, $urandom, $urandom);
            next_x = $urandom_range(1000);
        end else if (k < 5) begin
            send(FUNC_UNUSED, $urandom, $urandom, $urandom);
        end else if (k < 40) begin
            if ($urandom_range(9) == 0) next_x = $urandom;
            else next_x = next_x + $urandom_range(1 << $urandom_range(24), 1);
            send(FUNC_APPEND, next_x, rand_word(), $urandom);
        end else begin
            if (board.count > 0 && $urandom_range(3) != 0)
                send(FUNC_QUERY, $urandom, $urandom,
                     board.kx[$urandom_range(board.count - 1)] + $urandom_range(4096) - 2048);
            else
                send(FUNC_QUERY, $urandom, $urandom, rand_word());
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send(FUNC_QUERY, 0, 0, 32'h1234);
        send(FUNC_APPEND, 32'h0001_0000, 32'h8000_0000, 0);
        send(FUNC_QUERY, 0, 0, 0);
        send(FUNC_QUERY, 0, 0, 32'h0001_0000);
        send(FUNC_QUERY, 0, 0, 32'hFFFF_FFFF);
        send(FUNC_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send(FUNC_QUERY, 0, 0, 32'h8000_0000);
        send(FUNC_QUERY, 0, 0, 32'hFFFF_FFFF);
        send(FUNC_APPEND, 32'h0000_8000, 32'h0001_0000, 0);
        send(FUNC_QUERY, 0, 0, 32'h0002_0000);
        send(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(FUNC_CLEAR, 0, 0, 0);
        send(FUNC_QUERY, 0, 0, 5);
        drain();
        for (int i = 0; i < MaxKnots + 2; i++)
            send(FUNC_APPEND, 32'(i) << 20, $urandom, 0);
        send(FUNC_QUERY, 0, 0, 32'h0123_4567);
        send(FUNC_CLEAR, 0, 0, 0);
        next_x = 0;
        for (int n = 0; n < 900; n++) begin
            idle_pct = (n >= 300 && n < 450) ? 0 : 24;
            random_item();
        end
        drain();
        if (board.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
